@@ rtl/core/obrb_pkg.sv @@
// ----------------------------------------------------------------------------
// obrb_pkg
// Shared types, widths and helpers for the overwriting byte ring buffer.
// ----------------------------------------------------------------------------
package obrb_pkg;

   localparam int OBRB_DEPTH = 256;

   localparam int CMD_W  = 3;
   localparam int DATA_W = 32;
   localparam int OFF_W  = 8;
   localparam int CNT_W  = 9;
   localparam int DROP_W = 3;
   localparam int BYTE_W = 8;

   // largest capacity the 9-bit register can name
   localparam int MAX_CAP   = 511;
   localparam int RESET_CAP = 256;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BYTE = 3'd0,
      CMD_PUSH_WORD = 3'd1,
      CMD_POP_BYTE  = 3'd2,
      CMD_POP_WORD  = 3'd3,
      CMD_PEEK_BYTE = 3'd4,
      CMD_PEEK_WORD = 3'd5
   } cmd_type;

   // entries actually addressable: pointers always stay below capacity
   function automatic int obrb_store_depth(input int depth);
      return (depth > MAX_CAP) ? MAX_CAP : depth;
   endfunction

   function automatic int obrb_reset_cap(input int depth);
      return (depth > RESET_CAP) ? RESET_CAP : depth;
   endfunction

endpackage

@@ rtl/core/obrb_ram.sv @@
// ----------------------------------------------------------------------------
// obrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module obrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/obrb_wrap_add.sv @@
// ----------------------------------------------------------------------------
// obrb_wrap_add
// Shared address unit: base plus step, folded back once below the capacity.
// ----------------------------------------------------------------------------
module obrb_wrap_add #(
   parameter int AW = 8
) (
   input  logic [AW-1:0]              base,
   input  logic [obrb_pkg::OFF_W-1:0] step,
   input  logic [obrb_pkg::CNT_W-1:0] limit,
   output logic [AW-1:0]              result
);

   import obrb_pkg::*;

   localparam int SUM_W = ((AW > CNT_W) ? AW : CNT_W) + 1;

   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] lim;
   logic [SUM_W-1:0] folded;

   assign sum    = SUM_W'(base) + SUM_W'(step);
   assign lim    = SUM_W'(limit);
   assign folded = (sum >= lim) ? (sum - lim) : sum;
   assign result = folded[AW-1:0];

endmodule

@@ rtl/core/obrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// obrb_ctrl
// Command sequencer: pointers, count and capacity, one byte slot per cycle.
// ----------------------------------------------------------------------------
module obrb_ctrl #(
   parameter int DEPTH = obrb_pkg::OBRB_DEPTH,
   parameter int AW    = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [obrb_pkg::CMD_W-1:0]         req_command,
   input  logic [obrb_pkg::DATA_W-1:0]        req_push_data,
   input  logic [obrb_pkg::OFF_W-1:0]         req_peek_offset,
   output logic                               rsp_valid,
   output logic [obrb_pkg::DATA_W-1:0]        rsp_read_data,
   output logic                               rsp_status,
   output logic [obrb_pkg::DROP_W-1:0]        rsp_dropped,
   output logic [obrb_pkg::CNT_W-1:0]         rsp_fill_count,
   output logic                               rsp_is_empty,
   input  logic                               csr_wr_en,
   input  logic [obrb_pkg::CNT_W-1:0]         csr_wr_data,
   output logic                               mem_wr_en,
   output logic [AW-1:0]                      mem_wr_addr,
   output logic [obrb_pkg::BYTE_W-1:0]        mem_wr_data,
   output logic [AW-1:0]                      mem_rd_addr,
   input  logic [obrb_pkg::BYTE_W-1:0]        mem_rd_data,
   output logic [AW-1:0]                      unit_base,
   output logic [obrb_pkg::OFF_W-1:0]         unit_step,
   output logic [obrb_pkg::CNT_W-1:0]         unit_limit,
   input  logic [AW-1:0]                      unit_result
);

   import obrb_pkg::*;

   localparam int CAP_RESET_I = obrb_reset_cap(DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DRAIN,
      S_RESP
   } state_type;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [1:0]        k_ff, k_in;
   logic [1:0]        k_prev;
   logic [AW-1:0]     rp_ff, rp_in;
   logic [AW-1:0]     wp_ff, wp_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [DATA_W-1:0] rdata_ff, rdata_in;
   logic              status_ff, status_in;
   logic [DROP_W-1:0] dropped_ff, dropped_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic is_word, is_push, is_pop, last_slot, cfg_ok;

   assign k_prev    = k_ff - 2'd1;
   assign is_word   = (cmd_ff == CMD_PUSH_WORD) || (cmd_ff == CMD_POP_WORD) ||
                      (cmd_ff == CMD_PEEK_WORD);
   assign is_push   = (cmd_ff == CMD_PUSH_BYTE) || (cmd_ff == CMD_PUSH_WORD);
   assign is_pop    = (cmd_ff == CMD_POP_BYTE) || (cmd_ff == CMD_POP_WORD);
   assign last_slot = is_word ? (k_ff == 2'd3) : (k_ff == 2'd0);
   assign cfg_ok    = (csr_wr_data != '0) && (32'(csr_wr_data) <= 32'(DEPTH));

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      data_in     = data_ff;
      off_in      = off_ff;
      k_in        = k_ff;
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      count_in    = count_ff;
      cap_in      = cap_ff;
      rdata_in    = rdata_ff;
      status_in   = status_ff;
      dropped_in  = dropped_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = wp_ff;
      mem_wr_data = data_ff[{k_ff, 3'b000} +: BYTE_W];
      mem_rd_addr = rp_ff;
      unit_base   = rp_ff;
      unit_step   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in     = cmd_type'(req_command);
               data_in    = req_push_data;
               off_in     = req_peek_offset;
               k_in       = 2'd0;
               rdata_in   = '0;
               status_in  = 1'b0;
               dropped_in = '0;
               state_in   = S_RUN;
               unique case (req_command) inside
                  CMD_PUSH_BYTE, CMD_PUSH_WORD: begin
                     state_in = S_RUN;
                  end
                  CMD_POP_BYTE: begin
                     status_in = (count_ff == '0);
                  end
                  CMD_POP_WORD, CMD_PEEK_WORD: begin
                     status_in = (count_ff < CNT_W'(4));
                  end
                  CMD_PEEK_BYTE: begin
                     status_in = (CNT_W'(req_peek_offset) >= count_ff);
                  end
                  default: begin
                     // unknown command: empty result, nothing touched
                     state_in = S_RESP;
                  end
               endcase
               if (status_in) begin
                  state_in = S_RESP;
               end
            end
         end
         S_RUN: begin
            if (is_push) begin
               unit_base   = wp_ff;
               unit_step   = OFF_W'(1);
               mem_wr_en   = 1'b1;
               wp_in       = unit_result;
               if (count_ff >= cap_ff) begin
                  // full ring: read and write pointers coincide, both move on
                  rp_in      = unit_result;
                  dropped_in = dropped_ff + DROP_W'(1);
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end else if (is_pop) begin
               unit_base   = rp_ff;
               unit_step   = OFF_W'(1);
               mem_rd_addr = rp_ff;
               rp_in       = unit_result;
               count_in    = count_ff - CNT_W'(1);
            end else begin
               unit_base   = rp_ff;
               unit_step   = is_word ? OFF_W'(k_ff) : off_ff;
               mem_rd_addr = unit_result;
            end
            // read data of the previous slot lands this cycle
            if (!is_push && (k_ff != 2'd0)) begin
               rdata_in[{k_prev, 3'b000} +: BYTE_W] = mem_rd_data;
            end
            if (last_slot) begin
               state_in = is_push ? S_RESP : S_DRAIN;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_DRAIN: begin
            rdata_in[{k_ff, 3'b000} +: BYTE_W] = mem_rd_data;
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr_en && cfg_ok) begin
         cap_in   = csr_wr_data;
         rp_in    = '0;
         wp_in    = '0;
         count_in = '0;
      end

      rsp_valid_in = (state_in == S_RESP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmd_ff       <= CMD_PUSH_BYTE;
         data_ff      <= '0;
         off_ff       <= '0;
         k_ff         <= '0;
         rp_ff        <= '0;
         wp_ff        <= '0;
         count_ff     <= '0;
         cap_ff       <= CNT_W'(CAP_RESET_I);
         rdata_ff     <= '0;
         status_ff    <= 1'b0;
         dropped_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmd_ff       <= cmd_in;
         data_ff      <= data_in;
         off_ff       <= off_in;
         k_ff         <= k_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rdata_ff     <= rdata_in;
         status_ff    <= status_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign unit_limit     = cap_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rdata_ff;
   assign rsp_status     = status_ff;
   assign rsp_dropped    = dropped_ff;
   assign rsp_fill_count = count_ff;
   assign rsp_is_empty   = (count_ff == '0);

endmodule

@@ rtl/core/overwriting_byte_ring_buffer.sv @@
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer
// Byte FIFO with programmable capacity that overwrites the oldest byte.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result word
// shows on the rsp_ ports for a single cycle with rsp_valid high, and the
// receiver must take it then. Byte slots take turns on the single byte-wide
// store port and the shared wrap adder. A push writes its slots, then answers;
// a pop or peek reads its slots, captures the last byte in a drain state, then
// answers; a short pop or peek or an unknown command goes straight to the
// answer. Busy falls in the cycle after the result strobe. A capacity write
// (1 up to DEPTH) empties the buffer; other values are ignored. Write capacity
// only while busy is low.
module overwriting_byte_ring_buffer #(
   parameter int DEPTH = obrb_pkg::OBRB_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [obrb_pkg::CMD_W-1:0]  req_command,
   input  logic [obrb_pkg::DATA_W-1:0] req_push_data,
   input  logic [obrb_pkg::OFF_W-1:0]  req_peek_offset,
   output logic                        rsp_valid,
   output logic [obrb_pkg::DATA_W-1:0] rsp_read_data,
   output logic                        rsp_status,
   output logic [obrb_pkg::DROP_W-1:0] rsp_dropped,
   output logic [obrb_pkg::CNT_W-1:0]  rsp_fill_count,
   output logic                        rsp_is_empty,
   input  logic                        csr_wr_en,
   input  logic [obrb_pkg::CNT_W-1:0]  csr_wr_data
);

   import obrb_pkg::*;

   localparam int STORE_DEPTH = obrb_store_depth(DEPTH);
   localparam int AW          = $clog2(STORE_DEPTH);

   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [BYTE_W-1:0] mem_wr_data;
   logic [AW-1:0]     mem_rd_addr;
   logic [BYTE_W-1:0] mem_rd_data;
   logic [AW-1:0]     unit_base;
   logic [OFF_W-1:0]  unit_step;
   logic [CNT_W-1:0]  unit_limit;
   logic [AW-1:0]     unit_result;

   obrb_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_push_data   (req_push_data),
      .req_peek_offset (req_peek_offset),
      .rsp_valid       (rsp_valid),
      .rsp_read_data   (rsp_read_data),
      .rsp_status      (rsp_status),
      .rsp_dropped     (rsp_dropped),
      .rsp_fill_count  (rsp_fill_count),
      .rsp_is_empty    (rsp_is_empty),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data),
      .unit_base       (unit_base),
      .unit_step       (unit_step),
      .unit_limit      (unit_limit),
      .unit_result     (unit_result)
   );

   obrb_wrap_add #(
      .AW (AW)
   ) u_wrap_add (
      .base   (unit_base),
      .step   (unit_step),
      .limit  (unit_limit),
      .result (unit_result)
   );

   obrb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

@@ tb/sv/overwriting_byte_ring_buffer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer_test
// Drives push, pop and peek commands in random bursts at several capacities,
// including full buffers that wrap and drop their oldest bytes, and checks
// every result word against a byte-level model of the ring kept in the bench.
// ----------------------------------------------------------------------------
module overwriting_byte_ring_buffer_test;
   import obrb_pkg::*;

   localparam int RING_DEPTH = OBRB_DEPTH;
   localparam int SETTLE_CYCLES = 10;
   localparam int REPORT_LIMIT = 10;
   localparam longint TIMEOUT_NS = 2_000_000;

   // command codes the block ignores
   localparam logic [CMD_W-1:0] CMD_RESERVED_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RESERVED_HI = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [DATA_W-1:0] push_data;
      logic [OFF_W-1:0]  peek_offset;
   } ring_cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              status;
      logic [DROP_W-1:0] dropped;
      logic [CNT_W-1:0]  fill_count;
      logic              is_empty;
   } ring_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [CMD_W-1:0]  req_command = '0;
   logic [DATA_W-1:0] req_push_data = '0;
   logic [OFF_W-1:0]  req_peek_offset = '0;
   logic rsp_valid;
   logic [DATA_W-1:0] rsp_read_data;
   logic rsp_status;
   logic [DROP_W-1:0] rsp_dropped;
   logic [CNT_W-1:0]  rsp_fill_count;
   logic rsp_is_empty;
   logic csr_wr_en = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   // bench copy of the ring
   logic [BYTE_W-1:0] ring_mem [0:RING_DEPTH-1];
   int unsigned ring_head = 0;
   int unsigned ring_tail = 0;
   int unsigned ring_held = 0;
   int unsigned ring_cap = RESET_CAP;

   ring_cmd_type   cmd_backlog[$];
   ring_reply_type ring_replies[$];
   ring_cmd_type   cmd_on_port;
   int unsigned cmds_queued = 0;
   int unsigned cmds_accepted = 0;
   int unsigned mismatches = 0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   overwriting_byte_ring_buffer #(.DEPTH(RING_DEPTH)) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_push_data(req_push_data),
      .req_peek_offset(req_peek_offset),
      .rsp_valid(rsp_valid),
      .rsp_read_data(rsp_read_data),
      .rsp_status(rsp_status),
      .rsp_dropped(rsp_dropped),
      .rsp_fill_count(rsp_fill_count),
      .rsp_is_empty(rsp_is_empty),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned ring_next(int unsigned p);
      return (p + 1 >= ring_cap) ? 0 : p + 1;
   endfunction

   function automatic logic [BYTE_W-1:0] ring_take();
      logic [BYTE_W-1:0] b;
      b = ring_mem[ring_head % RING_DEPTH];
      ring_head = ring_next(ring_head);
      ring_held--;
      return b;
   endfunction

   function automatic int unsigned ring_put(logic [BYTE_W-1:0] b);
      int unsigned lost;
      lost = 0;
      if (ring_held >= ring_cap) begin
         void'(ring_take());
         lost = 1;
      end
      ring_mem[ring_tail % RING_DEPTH] = b;
      ring_tail = ring_next(ring_tail);
      ring_held++;
      return lost;
   endfunction

   function automatic logic [BYTE_W-1:0] ring_look(int unsigned off);
      int unsigned idx;
      idx = ring_head + off;
      if (idx >= ring_cap) idx -= ring_cap;
      return ring_mem[idx % RING_DEPTH];
   endfunction

   function automatic ring_reply_type ring_execute(ring_cmd_type c);
      ring_reply_type r;
      int unsigned lost;
      int i;
      r = '0;
      lost = 0;
      case (c.command)
         CMD_PUSH_BYTE: lost = ring_put(c.push_data[7:0]);
         CMD_PUSH_WORD: begin
            for (i = 0; i < 4; i++) lost += ring_put(c.push_data[8*i +: 8]);
         end
         CMD_POP_BYTE: begin
            if (ring_held < 1) r.status = 1'b1;
            else r.read_data[7:0] = ring_take();
         end
         CMD_POP_WORD: begin
            if (ring_held < 4) r.status = 1'b1;
            else for (i = 0; i < 4; i++) r.read_data[8*i +: 8] = ring_take();
         end
         CMD_PEEK_BYTE: begin
            if (c.peek_offset >= ring_held) r.status = 1'b1;
            else r.read_data[7:0] = ring_look(c.peek_offset);
         end
         CMD_PEEK_WORD: begin
            if (ring_held < 4) r.status = 1'b1;
            else for (i = 0; i < 4; i++) r.read_data[8*i +: 8] = ring_look(i);
         end
         default: ;
      endcase
      r.dropped = lost[DROP_W-1:0];
      r.fill_count = ring_held[CNT_W-1:0];
      r.is_empty = (ring_held == 0);
      return r;
   endfunction

   task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data,
                            logic [OFF_W-1:0] off);
      ring_cmd_type c;
      c.command = cmd;
      c.push_data = data;
      c.peek_offset = off;
      cmd_backlog.push_back(c);
      cmds_queued++;
   endtask

   // wait until every queued word has been taken and answered
   task automatic drain_ring();
      while (cmds_accepted != cmds_queued || ring_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(logic [CNT_W-1:0] value);
      drain_ring();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      // zero and anything above the store size leave the ring untouched
      if (value != 0 && value <= RING_DEPTH) begin
         ring_cap = value;
         ring_head = 0;
         ring_tail = 0;
         ring_held = 0;
      end
   endtask

   task automatic run_phase(logic [CNT_W-1:0] cap_value, int unsigned n_cmds,
                            int unsigned push_pct);
      int unsigned roll;
      int unsigned off_top;
      logic [CMD_W-1:0] cmd;
      logic [OFF_W-1:0] off;
      set_capacity(cap_value);
      off_top = (ring_cap > 255) ? 255 : ring_cap;
      repeat (n_cmds) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            cmd = $urandom_range(0, 1) ? CMD_RESERVED_LO : CMD_RESERVED_HI;
         end else if (roll < 3 + push_pct) begin
            cmd = $urandom_range(0, 1) ? CMD_PUSH_BYTE : CMD_PUSH_WORD;
         end else begin
            case ($urandom_range(0, 3))
               0: cmd = CMD_POP_BYTE;
               1: cmd = CMD_POP_WORD;
               2: cmd = CMD_PEEK_BYTE;
               default: cmd = CMD_PEEK_WORD;
            endcase
         end
         off = ($urandom_range(0, 3) == 0) ? OFF_W'($urandom())
                                           : OFF_W'($urandom_range(0, off_top));
         queue_cmd(cmd, $urandom(), off);
      end
   endtask

   // driver: one word on the request ports until it is taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            ring_replies.push_back(ring_execute(cmd_on_port));
            cmds_accepted++;
         end
         if (start && busy) begin
            // hold
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (cmd_backlog.size() != 0) begin
            cmd_on_port = cmd_backlog.pop_front();
            req_command <= cmd_on_port.command;
            req_push_data <= cmd_on_port.push_data;
            req_peek_offset <= cmd_on_port.peek_offset;
            start <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every result word is taken in the cycle it shows
   always @(posedge clock) begin
      ring_reply_type want;
      if (!reset && rsp_valid) begin
         if (ring_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result word: data %h status %0d dropped %0d fill %0d",
                        rsp_read_data, rsp_status, rsp_dropped, rsp_fill_count);
         end else begin
            want = ring_replies.pop_front();
            if (rsp_read_data !== want.read_data || rsp_status !== want.status ||
                rsp_dropped !== want.dropped || rsp_fill_count !== want.fill_count ||
                rsp_is_empty !== want.is_empty) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display({"mismatch: expected data %h st %0d drop %0d fill %0d empty %0d,",
                            " got data %h st %0d drop %0d fill %0d empty %0d"},
                           want.read_data, want.status, want.dropped, want.fill_count,
                           want.is_empty, rsp_read_data, rsp_status, rsp_dropped,
                           rsp_fill_count, rsp_is_empty);
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("overwriting_byte_ring_buffer test failed");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // short reads on an empty ring, reserved codes
      queue_cmd(CMD_POP_BYTE, 32'h0, 8'h00);
      queue_cmd(CMD_POP_WORD, 32'h0, 8'h00);
      queue_cmd(CMD_PEEK_BYTE, 32'h0, 8'h00);
      queue_cmd(CMD_PEEK_WORD, 32'h0, 8'h00);
      queue_cmd(CMD_RESERVED_LO, 32'h0, 8'h00);
      queue_cmd(CMD_RESERVED_HI, 32'hFFFF_FFFF, 8'hFF);
      // push byte ignores the upper bits
      queue_cmd(CMD_PUSH_BYTE, 32'hFFFF_FF80, 8'h00);
      queue_cmd(CMD_PEEK_BYTE, 32'h0, 8'h00);
      queue_cmd(CMD_PEEK_BYTE, 32'h0, 8'h01);
      queue_cmd(CMD_POP_WORD, 32'h0, 8'h00);
      // bytes with the top bit set must not sign-extend into the word
      queue_cmd(CMD_PUSH_WORD, 32'h8040_20FF, 8'h00);
      queue_cmd(CMD_PEEK_WORD, 32'h0, 8'h00);
      queue_cmd(CMD_PEEK_BYTE, 32'h0, 8'h04);
      queue_cmd(CMD_POP_BYTE, 32'h0, 8'h00);
      queue_cmd(CMD_POP_WORD, 32'h0, 8'h00);
      queue_cmd(CMD_PUSH_WORD, 32'hFFFF_FFFF, 8'h00);
      queue_cmd(CMD_PUSH_WORD, 32'h0000_0000, 8'h00);
      queue_cmd(CMD_PEEK_BYTE, 32'h0, 8'h07);
      queue_cmd(CMD_PEEK_BYTE, 32'h0, 8'hFF);
      queue_cmd(CMD_POP_WORD, 32'h0, 8'h00);
      queue_cmd(CMD_POP_WORD, 32'h0, 8'h00);
      queue_cmd(CMD_POP_BYTE, 32'h0, 8'h00);
      queue_cmd(CMD_PUSH_BYTE, 32'h0000_007F, 8'h00);

      // ignored capacity writes keep the stored byte
      set_capacity(9'd0);
      queue_cmd(CMD_PEEK_BYTE, 32'h0, 8'h00);
      set_capacity(9'd511);
      set_capacity(9'd257);
      queue_cmd(CMD_PEEK_WORD, 32'h0, 8'h00);
      queue_cmd(CMD_POP_BYTE, 32'h0, 8'h00);

      run_phase(9'd256, 80, 45);
      // capacity one: every word push overwrites
      run_phase(9'd1, 60, 45);
      // fill the largest ring so it wraps and peeks reach offset 255
      run_phase(9'd256, 130, 80);
      run_phase(9'd4, 80, 45);
      run_phase(9'd5, 70, 50);
      run_phase(CNT_W'($urandom_range(2, 255)), 80, 50);
      run_phase(9'd2, 50, 45);
      run_phase(CNT_W'($urandom_range(6, 40)), 80, 55);
      run_phase(9'd3, 50, 40);

      drain_ring();
      if (mismatches == 0) begin
         $display("overwriting_byte_ring_buffer test passed");
      end else begin
         $display("overwriting_byte_ring_buffer test failed");
      end
      $finish;
   end

endmodule
